[src/cdcc_pkg.sv]
package cdcc_pkg;

    localparam int NumDigits = 9;
    localparam int DigitW    = 4;

    typedef logic [DigitW-1:0] digit_t;
    typedef digit_t [NumDigits-1:0] digit_vec_t;

    localparam digit_t DigitReset = 4'd2;

    // Wrap limits for an increment, digit 8 first. Hour digits are
    // overridden by the hour rules.
    localparam digit_vec_t DigitLimit = {
        4'd9, 4'd9, 4'd9, 4'd2, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9
    };

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_INC  = 1'b1
    } op_t;

    typedef struct packed {
        op_t        opcode;
        logic [3:0] digit_index;
    } in_word_t;

    typedef struct packed {
        digit_vec_t digits;
        logic       expired;
    } out_word_t;

endpackage

[src/cdcc_step.sv]
module cdcc_step (
    input  cdcc_pkg::digit_vec_t digits,
    input  logic                 expired,
    input  logic                 clock_mode,
    input  cdcc_pkg::in_word_t   item,
    output cdcc_pkg::digit_vec_t digits_next,
    output logic                 expired_next
);

    function automatic cdcc_pkg::digit_t dec_wrap(input cdcc_pkg::digit_t d,
                                                  input cdcc_pkg::digit_t lim);
        return (d != 4'd0) ? d - 4'd1 : lim;
    endfunction

    function automatic cdcc_pkg::digit_t inc_wrap(input cdcc_pkg::digit_t d,
                                                  input cdcc_pkg::digit_t lim);
        return (d < lim) ? d + 4'd1 : 4'd0;
    endfunction

    cdcc_pkg::digit_vec_t dn;
    cdcc_pkg::digit_vec_t up;
    cdcc_pkg::digit_vec_t ed;
    logic                 dn_expired;
    logic                 b0, b1, b2, b3, bh, b6, b7;
    logic                 c0, c1, c2, c3;
    cdcc_pkg::digit_t     wd;
    cdcc_pkg::digit_t     lim4;
    cdcc_pkg::digit_t     lim5;

    // Countdown tick: the borrow ripples from seconds units to day hundreds.
    always_comb begin
        dn         = digits;
        dn_expired = expired;
        bh         = 1'b0;
        b6         = 1'b0;
        b7         = 1'b0;
        b0         = (digits[0] == 4'd0);
        b1         = b0 && (digits[1] == 4'd0);
        b2         = b1 && (digits[2] == 4'd0);
        b3         = b2 && (digits[3] == 4'd0);
        dn[0]      = dec_wrap(digits[0], 4'd9);
        if (b0) begin
            dn[1] = dec_wrap(digits[1], 4'd5);
        end
        if (b1) begin
            dn[2] = dec_wrap(digits[2], 4'd9);
        end
        if (b2) begin
            dn[3] = dec_wrap(digits[3], 4'd5);
        end
        if (b3) begin
            if (digits[5] > 4'd2 || (digits[5] == 4'd2 && digits[4] > 4'd3)) begin
                dn[5] = 4'd2;
                dn[4] = 4'd3;
            end else if (digits[4] != 4'd0) begin
                dn[4] = digits[4] - 4'd1;
            end else if (digits[5] != 4'd0) begin
                dn[4] = 4'd9;
                dn[5] = digits[5] - 4'd1;
            end else begin
                dn[5] = 4'd2;
                dn[4] = 4'd3;
                bh    = 1'b1;
            end
        end
        if (bh) begin
            dn[6] = dec_wrap(digits[6], 4'd9);
            b6    = (digits[6] == 4'd0);
        end
        if (b6) begin
            dn[7] = dec_wrap(digits[7], 4'd9);
            b7    = (digits[7] == 4'd0);
        end
        if (b7) begin
            if (digits[8] != 4'd0) begin
                dn[8] = digits[8] - 4'd1;
            end else begin
                dn_expired = 1'b1;
            end
        end
    end

    // Clock tick: repair the weekday and clear the upper day digits first.
    always_comb begin
        up    = digits;
        up[7] = 4'd0;
        up[8] = 4'd0;
        wd    = digits[6];
        if (wd == 4'd0 || wd == 4'd8 || wd == 4'd9) begin
            wd = 4'd1;
        end
        up[6] = wd;
        c0    = (digits[0] >= 4'd9);
        c1    = c0 && (digits[1] >= 4'd5);
        c2    = c1 && (digits[2] >= 4'd9);
        c3    = c2 && (digits[3] >= 4'd5);
        up[0] = inc_wrap(digits[0], 4'd9);
        if (c0) begin
            up[1] = inc_wrap(digits[1], 4'd5);
        end
        if (c1) begin
            up[2] = inc_wrap(digits[2], 4'd9);
        end
        if (c2) begin
            up[3] = inc_wrap(digits[3], 4'd5);
        end
        if (c3) begin
            if (digits[5] < 4'd2 || (digits[5] == 4'd2 && digits[4] < 4'd3)) begin
                if (digits[4] >= 4'd9) begin
                    up[4] = 4'd0;
                    up[5] = digits[5] + 4'd1;
                end else begin
                    up[4] = digits[4] + 4'd1;
                end
            end else begin
                up[4] = 4'd0;
                up[5] = 4'd0;
                up[6] = (wd < 4'd7) ? wd + 4'd1 : 4'd1;
            end
        end
    end

    // Digit edit with the hour limits depending on the other hour digit.
    always_comb begin
        lim4 = (digits[5] >= 4'd2) ? 4'd3 : 4'd9;
        lim5 = (digits[4] <= 4'd3) ? 4'd2 : 4'd1;
        ed   = digits;
        for (int i = 0; i < cdcc_pkg::NumDigits; i++) begin
            if (item.digit_index == 4'(i)) begin
                if (i == 4) begin
                    ed[i] = inc_wrap(digits[i], lim4);
                end else if (i == 5) begin
                    ed[i] = inc_wrap(digits[i], lim5);
                end else begin
                    ed[i] = inc_wrap(digits[i], cdcc_pkg::DigitLimit[i]);
                end
            end
        end
    end

    always_comb begin
        digits_next  = digits;
        expired_next = expired;
        if (item.opcode == cdcc_pkg::OP_INC) begin
            digits_next = ed;
        end else if (!expired) begin
            if (clock_mode) begin
                digits_next = up;
            end else begin
                digits_next  = dn;
                expired_next = dn_expired;
            end
        end
    end

endmodule

[src/countdown_and_clock_digit_counter_core.sv]
// Nine-digit BCD countdown timer and 24-hour clock with weekday.
// Input channel s_valid/s_ready/s_data carries one word per operation: a
// one-second tick or an increment of the digit named by digit_index.
// Result channel m_valid/m_ready/m_data returns one word per input word:
// all nine digits and the sticky expired flag after the operation acted.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes clock_mode
// (0 countdown, 1 clock); it is always ready. It is to be written while
// idle; the block itself does not enforce this. An accepted word is held
// in an input register; the digit update, ripple included, runs through
// one pass of logic into the state and result registers behind m_valid.
// Throughput is one word per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its word and the
// input register takes one more word before s_ready drops.
// Reset clears both valid flags and expiry, selects countdown mode and
// loads every digit with 2.
module countdown_and_clock_digit_counter_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cdcc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cdcc_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    logic                 in_valid_reg;
    cdcc_pkg::in_word_t   in_data_reg;
    logic                 out_valid_reg;
    cdcc_pkg::out_word_t  out_data_reg;
    cdcc_pkg::digit_vec_t digits_reg;
    cdcc_pkg::digit_vec_t digits_next;
    logic                 expired_reg;
    logic                 expired_next;
    logic                 clock_mode_reg;
    logic                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    cdcc_step u_step (
        .digits       (digits_reg),
        .expired      (expired_reg),
        .clock_mode   (clock_mode_reg),
        .item         (in_data_reg),
        .digits_next  (digits_next),
        .expired_next (expired_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            expired_reg    <= 1'b0;
            clock_mode_reg <= 1'b0;
            digits_reg     <= {cdcc_pkg::NumDigits{cdcc_pkg::DigitReset}};
        end else begin
            if (cfg_valid && cfg_ready) begin
                clock_mode_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                digits_reg    <= digits_next;
                expired_reg   <= expired_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg.digits  <= digits_next;
            out_data_reg.expired <= expired_next;
        end
    end

    a_expired_sticky: assert property (
        @(posedge aclk) disable iff (!aresetn)
        expired_reg |=> expired_reg
    ) else $error("expired flag cleared without reset");

    a_result_matches_state: assert property (
        @(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.digits == digits_reg &&
                           out_data_reg.expired == expired_reg)
    ) else $error("pending result word differs from digit state");

    a_clock_tick_clears_days: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && clock_mode_reg && !expired_reg &&
         in_data_reg.opcode == cdcc_pkg::OP_TICK)
        |=> (digits_reg[7] == 4'd0 && digits_reg[8] == 4'd0)
    ) else $error("clock tick left day tens or hundreds nonzero");

    a_hour_tens_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        digits_reg[5] <= 4'd2
    ) else $error("hour tens digit out of range");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int SEC_UNITS    = 0;
    localparam int SEC_TENS     = 1;
    localparam int MIN_UNITS    = 2;
    localparam int MIN_TENS     = 3;
    localparam int HOUR_UNITS   = 4;
    localparam int HOUR_TENS    = 5;
    localparam int DAY_UNITS    = 6;
    localparam int WEEKDAY      = 6;
    localparam int DAY_TENS     = 7;
    localparam int DAY_HUNDREDS = 8;

    localparam int HOURS_MAX   = 23;
    localparam int WEEKDAY_MAX = 7;

    localparam logic MODE_COUNTDOWN = 1'b0;
    localparam logic MODE_CLOCK     = 1'b1;

    // Wrap limit of each digit, digit 8 in the top nibble.
    localparam cdcc_pkg::digit_vec_t WRAP_LIMITS = 36'h999295959;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 60;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    cdcc_pkg::in_word_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    cdcc_pkg::out_word_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    countdown_and_clock_digit_counter_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    cdcc_pkg::digit_vec_t face_digits  = {cdcc_pkg::NumDigits{cdcc_pkg::DigitReset}};
    logic                 face_expired = 1'b0;
    logic                 face_mode    = MODE_COUNTDOWN;

    cdcc_pkg::in_word_t  ops_pending[$];
    cdcc_pkg::out_word_t expected_faces[$];

    int   ops_queued      = 0;
    int   mismatches      = 0;
    int   quiet_cycles    = 0;
    logic in_accept       = 1'b0;
    logic calm            = 1'b0;
    logic final_phase     = 1'b0;
    logic long_hold_req   = 1'b0;
    logic long_hold_begun = 1'b0;
    int   long_hold_left  = 0;
    int   send_gap        = 0;
    int   stall_left      = 0;

    function automatic cdcc_pkg::digit_t edit_limit(int i);
        if (i == HOUR_UNITS) return (face_digits[HOUR_TENS] >= 2) ? 4'd3 : 4'd9;
        if (i == HOUR_TENS) return (face_digits[HOUR_UNITS] <= 3) ? 4'd2 : 4'd1;
        return WRAP_LIMITS[i];
    endfunction

    function automatic bit borrow_digit(int i);
        if (face_digits[i] > 0) begin
            face_digits[i] -= 4'd1;
            return 1'b0;
        end
        face_digits[i] = WRAP_LIMITS[i];
        return 1'b1;
    endfunction

    function automatic bit carry_digit(int i, cdcc_pkg::digit_t lim);
        if (face_digits[i] < lim) begin
            face_digits[i] += 4'd1;
            return 1'b0;
        end
        face_digits[i] = 4'd0;
        return 1'b1;
    endfunction

    function automatic int face_hours();
        return int'(face_digits[HOUR_TENS]) * 10 + int'(face_digits[HOUR_UNITS]);
    endfunction

    task automatic put_hours(int h);
        face_digits[HOUR_UNITS] = cdcc_pkg::digit_t'(h % 10);
        face_digits[HOUR_TENS]  = cdcc_pkg::digit_t'((h / 10) % 10);
    endtask

    task automatic count_down();
        int h;
        if (!borrow_digit(SEC_UNITS)) return;
        if (!borrow_digit(SEC_TENS)) return;
        if (!borrow_digit(MIN_UNITS)) return;
        if (!borrow_digit(MIN_TENS)) return;
        h = face_hours();
        if (h > 0) begin
            put_hours(h > HOURS_MAX ? HOURS_MAX : h - 1);
            return;
        end
        put_hours(HOURS_MAX);
        if (!borrow_digit(DAY_UNITS)) return;
        if (!borrow_digit(DAY_TENS)) return;
        if (face_digits[DAY_HUNDREDS] > 0) begin
            face_digits[DAY_HUNDREDS] -= 4'd1;
            return;
        end
        face_expired = 1'b1;
    endtask

    task automatic count_up();
        int h;
        face_digits[DAY_TENS]     = 4'd0;
        face_digits[DAY_HUNDREDS] = 4'd0;
        if (face_digits[WEEKDAY] == 0 || face_digits[WEEKDAY] == 8 ||
            face_digits[WEEKDAY] == 9) face_digits[WEEKDAY] = 4'd1;
        if (!carry_digit(SEC_UNITS, WRAP_LIMITS[SEC_UNITS])) return;
        if (!carry_digit(SEC_TENS, WRAP_LIMITS[SEC_TENS])) return;
        if (!carry_digit(MIN_UNITS, WRAP_LIMITS[MIN_UNITS])) return;
        if (!carry_digit(MIN_TENS, WRAP_LIMITS[MIN_TENS])) return;
        h = face_hours();
        if (h < HOURS_MAX) begin
            put_hours(h + 1);
            return;
        end
        put_hours(0);
        if (face_digits[WEEKDAY] < WEEKDAY_MAX) face_digits[WEEKDAY] += 4'd1;
        else face_digits[WEEKDAY] = 4'd1;
    endtask

    task automatic apply_op(input cdcc_pkg::in_word_t w, output cdcc_pkg::out_word_t face);
        if (w.opcode == cdcc_pkg::OP_TICK) begin
            if (!face_expired) begin
                if (face_mode == MODE_CLOCK) count_up();
                else count_down();
            end
        end else if (w.digit_index < cdcc_pkg::NumDigits) begin
            void'(carry_digit(int'(w.digit_index), edit_limit(int'(w.digit_index))));
        end
        face.digits  = face_digits;
        face.expired = face_expired;
    endtask

    always @(posedge aclk) begin
        cdcc_pkg::out_word_t want;
        logic                out_accept;
        logic                cfg_accept;
        in_accept  = aresetn && s_valid && s_ready;
        out_accept = aresetn && m_valid && m_ready;
        cfg_accept = aresetn && cfg_valid && cfg_ready;
        if (cfg_accept) face_mode = cfg_data;
        if (out_accept) begin
            if (expected_faces.size() == 0) begin
                mismatches++;
                $display("%0t: result word %h with nothing expected", $time, m_data);
            end else begin
                want = expected_faces.pop_front();
                if (m_data.digits !== want.digits) begin
                    mismatches++;
                    $display("%0t: digits expected %h, actual %h",
                             $time, want.digits, m_data.digits);
                end
                if (m_data.expired !== want.expired) begin
                    mismatches++;
                    $display("%0t: expired expected %b, actual %b",
                             $time, want.expired, m_data.expired);
                end
            end
        end
        if (in_accept) begin
            apply_op(s_data, want);
            expected_faces.push_back(want);
        end
        if (in_accept || out_accept || cfg_accept) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("countdown_and_clock_digit_counter_core regression: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!s_valid || in_accept) begin
            if (send_gap > 0) begin
                send_gap -= 1;
                s_valid <= 1'b0;
            end else if (!calm && ops_pending.size() != 0 && $urandom_range(0, 99) < 12) begin
                send_gap = $urandom_range(0, 2);
                s_valid <= 1'b0;
            end else if (ops_pending.size() != 0) begin
                s_data  <= ops_pending.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The result side can be told once to hold off long enough for the
    // block to fill up and drop s_ready.
    always @(negedge aclk) begin
        if (long_hold_req && !long_hold_begun) begin
            long_hold_begun = 1'b1;
            long_hold_left  = LONG_HOLD;
        end
        if (long_hold_left > 0) begin
            long_hold_left -= 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left -= 1;
            m_ready <= 1'b0;
        end else if (!calm && aresetn && $urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic queue_op(cdcc_pkg::op_t op, int idx);
        cdcc_pkg::in_word_t w;
        w.opcode      = op;
        w.digit_index = idx[3:0];
        ops_pending.push_back(w);
        ops_queued++;
    endtask

    task automatic wait_sent();
        while (ops_pending.size() != 0 || s_valid) @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (ops_pending.size() != 0 || s_valid || expected_faces.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_digit(int i, int target);
        int lim;
        int cur;
        int n;
        wait_sent();
        lim = int'(edit_limit(i));
        cur = int'(face_digits[i]);
        n = (cur <= lim) ? (target + lim + 1 - cur) % (lim + 1) : target + 1;
        repeat (n) queue_op(cdcc_pkg::OP_INC, i);
    endtask

    task automatic set_hours(int h);
        if (h / 10 == 2) begin
            set_digit(HOUR_UNITS, h % 10);
            set_digit(HOUR_TENS, h / 10);
        end else begin
            set_digit(HOUR_TENS, h / 10);
            set_digit(HOUR_UNITS, h % 10);
        end
    endtask

    // Before the expiry phase, random countdown edits picked here never touch
    // the day digits and day hundreds is kept at two or more, so the flag cannot set early.
    function automatic int pick_index();
        if (!final_phase && face_mode == MODE_COUNTDOWN) begin
            if ($urandom_range(0, 3) == 0) return $urandom_range(9, 15);
            return $urandom_range(SEC_UNITS, HOUR_TENS);
        end
        if ($urandom_range(0, 3) == 0) return $urandom_range(9, 15);
        return $urandom_range(SEC_UNITS, DAY_HUNDREDS);
    endfunction

    function automatic int near(int edge_val, int top);
        return $urandom_range(0, 1) ? edge_val : $urandom_range(0, top);
    endfunction

    task automatic queue_noise(int count);
        repeat (count) begin
            if ($urandom_range(0, 1)) queue_op(cdcc_pkg::OP_INC, pick_index());
            else queue_op(cdcc_pkg::OP_TICK, $urandom_range(0, 15));
        end
    endtask

    task automatic write_mode(logic mode);
        wait_drained();
        repeat (3) @(negedge aclk);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (mode == MODE_COUNTDOWN && !final_phase)
            set_digit(DAY_HUNDREDS, $urandom_range(2, 9));
    endtask

    task automatic run_scenario();
        if (face_mode == MODE_CLOCK) begin
            if ($urandom_range(0, 2) != 0) set_digit(DAY_HUNDREDS, $urandom_range(0, 9));
            if ($urandom_range(0, 2) != 0) set_digit(DAY_TENS, $urandom_range(0, 9));
            if ($urandom_range(0, 2) != 0) set_digit(WEEKDAY, near(WEEKDAY_MAX, 9));
            if ($urandom_range(0, 2) != 0) set_hours(near(HOURS_MAX, HOURS_MAX));
            if ($urandom_range(0, 2) != 0) set_digit(MIN_TENS, near(5, 5));
            if ($urandom_range(0, 2) != 0) set_digit(MIN_UNITS, near(9, 9));
            if ($urandom_range(0, 2) != 0) set_digit(SEC_TENS, near(5, 5));
            set_digit(SEC_UNITS, near(9, 9));
        end else begin
            if (!final_phase) set_digit(DAY_HUNDREDS, $urandom_range(2, 9));
            if ($urandom_range(0, 2) != 0) set_digit(DAY_TENS, near(0, 9));
            if ($urandom_range(0, 2) != 0) set_digit(DAY_UNITS, near(0, 9));
            if ($urandom_range(0, 2) != 0) set_hours(near(0, HOURS_MAX));
            if ($urandom_range(0, 2) != 0) set_digit(MIN_TENS, near(0, 5));
            if ($urandom_range(0, 2) != 0) set_digit(MIN_UNITS, near(0, 9));
            if ($urandom_range(0, 2) != 0) set_digit(SEC_TENS, near(0, 5));
            set_digit(SEC_UNITS, near(0, 9));
        end
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 4) == 0) queue_op(cdcc_pkg::OP_INC, pick_index());
            else queue_op(cdcc_pkg::OP_TICK, $urandom_range(0, 15));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_mode(MODE_COUNTDOWN);
        queue_op(cdcc_pkg::OP_TICK, 0);
        queue_op(cdcc_pkg::OP_TICK, 15);
        for (int i = SEC_UNITS; i <= DAY_HUNDREDS; i++) queue_op(cdcc_pkg::OP_INC, i);
        queue_op(cdcc_pkg::OP_INC, 9);
        queue_op(cdcc_pkg::OP_INC, 15);
        queue_op(cdcc_pkg::OP_TICK, 8);

        write_mode(MODE_CLOCK);
        queue_op(cdcc_pkg::OP_TICK, 0);
        queue_op(cdcc_pkg::OP_TICK, 7);
        queue_op(cdcc_pkg::OP_INC, WEEKDAY);
        queue_op(cdcc_pkg::OP_TICK, 0);
        queue_op(cdcc_pkg::OP_INC, HOUR_UNITS);
        queue_op(cdcc_pkg::OP_INC, HOUR_TENS);
        queue_op(cdcc_pkg::OP_TICK, 0);

        while (ops_queued < 700) begin
            if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
            if (!long_hold_req && ops_queued > 300) begin
                long_hold_req = 1'b1;
                queue_noise(40);
            end
            if ($urandom_range(0, 9) < 6) run_scenario();
            else queue_noise($urandom_range(8, 30));
        end

        // Run the countdown past zero, then check that ticks are ignored.
        final_phase = 1'b1;
        write_mode(MODE_COUNTDOWN);
        set_digit(DAY_HUNDREDS, 0);
        set_digit(DAY_TENS, 0);
        set_digit(DAY_UNITS, 0);
        set_hours(0);
        set_digit(MIN_TENS, 0);
        set_digit(MIN_UNITS, 0);
        set_digit(SEC_TENS, 0);
        set_digit(SEC_UNITS, $urandom_range(0, 2));
        repeat (6) queue_op(cdcc_pkg::OP_TICK, $urandom_range(0, 15));
        queue_noise(40);
        write_mode(MODE_CLOCK);
        calm = 1'b1;
        run_scenario();
        queue_noise(60);

        wait_drained();
        repeat (6) @(negedge aclk);
        if (mismatches == 0) begin
            $display("countdown_and_clock_digit_counter_core regression: pass");
        end else begin
            $display("countdown_and_clock_digit_counter_core regression: fail");
        end
        $finish;
    end

endmodule

[countdown_and_clock_digit_counter_core.f]
src/cdcc_pkg.sv
src/cdcc_step.sv
src/countdown_and_clock_digit_counter_core.sv
verif/testbench.sv
